// File: src/ps2h_pkg.sv
// PS/2 host transceiver package: item and result types, phase codes and
// protocol constants. No dependencies.
`timescale 1ns / 1ps

package ps2h_pkg;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [1:0] RX_IDLE   = 2'd0;
  localparam logic [1:0] RX_DATA   = 2'd1;
  localparam logic [1:0] RX_PARITY = 2'd2;
  localparam logic [1:0] RX_STOP   = 2'd3;

  localparam logic [1:0] TX_DATA   = 2'd0;
  localparam logic [1:0] TX_PARITY = 2'd1;
  localparam logic [1:0] TX_STOP   = 2'd2;
  localparam logic [1:0] TX_ACK    = 2'd3;

  localparam logic [3:0] TX_DATA_EDGES = 4'd9;
  localparam logic [3:0] RX_LAST_INDEX = 4'd7;
  localparam logic [3:0] TX_LAST_DATA  = 4'd8;

  localparam logic [1:0] RX_ERR_NONE   = 2'd0;
  localparam logic [1:0] RX_ERR_PARITY = 2'd1;
  localparam logic [1:0] RX_ERR_STOP   = 2'd2;

  localparam logic [1:0] TX_ST_NONE   = 2'd0;
  localparam logic [1:0] TX_ST_ACKED  = 2'd1;
  localparam logic [1:0] TX_ST_NO_ACK = 2'd2;

  typedef struct packed {
    logic       operation;
    logic       data_bit;
    logic [7:0] tx_byte;
  } in_t;

  typedef struct packed {
    logic       line_enable;
    logic       line_low;
    logic       start_request;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] rx_error;
    logic [1:0] tx_status;
  } res_t;

endpackage

// File: src/ps2h_if.sv
// Valid/ready channel interfaces for the PS/2 host transceiver.
// ps2h_in_if carries input beats, ps2h_out_if carries result beats.
`timescale 1ns / 1ps

interface ps2h_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       data_bit;
  logic [7:0] tx_byte;

  modport source (output valid, output operation, output data_bit, output tx_byte,
                  input ready);
  modport sink (input valid, input operation, input data_bit, input tx_byte,
                output ready);
endinterface

interface ps2h_out_if;
  logic       valid;
  logic       ready;
  logic       line_enable;
  logic       line_low;
  logic       start_request;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic [1:0] rx_error;
  logic [1:0] tx_status;

  modport source (output valid, output line_enable, output line_low,
                  output start_request, output rx_valid, output rx_byte,
                  output rx_error, output tx_status, input ready);
  modport sink (input valid, input line_enable, input line_low,
                input start_request, input rx_valid, input rx_byte,
                input rx_error, input tx_status, output ready);
endinterface

// File: src/ps2h_core.sv
// Protocol state and single-step update of the PS/2 host transceiver.
// Depends on ps2h_pkg. State advances only when step is high.
`timescale 1ns / 1ps

module ps2h_core import ps2h_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  item,
  output res_t res
);

  logic       sending_mode, sending_mode_next;
  logic [1:0] rx_phase, rx_phase_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic       rx_ones_odd, rx_ones_odd_next;
  logic [3:0] rx_bit_count, rx_bit_count_next;
  logic [1:0] tx_phase, tx_phase_next;
  logic [7:0] tx_shift, tx_shift_next;
  logic [3:0] tx_bit_count, tx_bit_count_next;

  logic [3:0] tx_count_inc;
  logic [3:0] rx_count_inc;
  logic [3:0] tx_count_dec;
  logic       tx_cur_bit;

  assign tx_count_inc = tx_bit_count + 4'd1;
  assign rx_count_inc = rx_bit_count + 4'd1;
  assign tx_count_dec = tx_bit_count - 4'd1;
  assign tx_cur_bit   = tx_shift[tx_count_dec[2:0]];

  always_comb begin
    sending_mode_next = sending_mode;
    rx_phase_next     = rx_phase;
    rx_shift_next     = rx_shift;
    rx_ones_odd_next  = rx_ones_odd;
    rx_bit_count_next = rx_bit_count;
    tx_phase_next     = tx_phase;
    tx_shift_next     = tx_shift;
    tx_bit_count_next = tx_bit_count;
    res               = '0;

    priority if (item.operation == OP_SEND) begin
      // send request restarts any transfer and drops a partial frame
      sending_mode_next = 1'b1;
      tx_shift_next     = item.tx_byte;
      tx_bit_count_next = 4'd0;
      tx_phase_next     = TX_DATA;
      rx_phase_next     = RX_IDLE;
      res.start_request = 1'b1;
      res.line_enable   = 1'b1;
      res.line_low      = 1'b1;
    end else if (sending_mode) begin
      unique case (tx_phase)
        TX_DATA: begin
          res.line_enable = 1'b1;
          // count 0 is the start bit
          if (tx_bit_count == 4'd0 || tx_bit_count > TX_LAST_DATA) begin
            res.line_low = 1'b1;
          end else begin
            res.line_low = ~tx_cur_bit;
          end
          tx_bit_count_next = tx_count_inc;
          if (tx_count_inc >= TX_DATA_EDGES) begin
            tx_phase_next = TX_PARITY;
          end
        end
        TX_PARITY: begin
          res.line_enable = 1'b1;
          res.line_low    = ^tx_shift;
          tx_phase_next   = TX_STOP;
        end
        TX_STOP: begin
          tx_phase_next = TX_ACK;
        end
        default: begin
          res.tx_status     = item.data_bit ? TX_ST_NO_ACK : TX_ST_ACKED;
          tx_phase_next     = TX_DATA;
          tx_bit_count_next = 4'd0;
          sending_mode_next = 1'b0;
        end
      endcase
    end else begin
      unique case (rx_phase)
        RX_IDLE: begin
          if (!item.data_bit) begin
            rx_phase_next     = RX_DATA;
            rx_shift_next     = 8'd0;
            rx_ones_odd_next  = 1'b0;
            rx_bit_count_next = 4'd0;
          end
        end
        RX_DATA: begin
          rx_shift_next     = {item.data_bit, rx_shift[7:1]};
          rx_ones_odd_next  = rx_ones_odd ^ item.data_bit;
          rx_bit_count_next = rx_count_inc;
          if (rx_count_inc > RX_LAST_INDEX) begin
            rx_phase_next = RX_PARITY;
          end
        end
        RX_PARITY: begin
          if (rx_ones_odd == item.data_bit) begin
            res.rx_valid  = 1'b1;
            res.rx_error  = RX_ERR_PARITY;
            res.rx_byte   = rx_shift;
            rx_phase_next = RX_IDLE;
          end else begin
            rx_phase_next = RX_STOP;
          end
        end
        default: begin
          res.rx_valid  = 1'b1;
          res.rx_byte   = rx_shift;
          res.rx_error  = item.data_bit ? RX_ERR_NONE : RX_ERR_STOP;
          rx_phase_next = RX_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending_mode <= 1'b0;
      rx_phase     <= RX_IDLE;
      rx_shift     <= 8'd0;
      rx_ones_odd  <= 1'b0;
      rx_bit_count <= 4'd0;
      tx_phase     <= TX_DATA;
      tx_shift     <= 8'd0;
      tx_bit_count <= 4'd0;
    end else if (step) begin
      sending_mode <= sending_mode_next;
      rx_phase     <= rx_phase_next;
      rx_shift     <= rx_shift_next;
      rx_ones_odd  <= rx_ones_odd_next;
      rx_bit_count <= rx_bit_count_next;
      tx_phase     <= tx_phase_next;
      tx_shift     <= tx_shift_next;
      tx_bit_count <= tx_bit_count_next;
    end
  end

`ifndef SYNTHESIS
  a_tx_count_bound: assert property (@(posedge clk) disable iff (rst)
    tx_bit_count <= TX_DATA_EDGES)
    else $error("tx bit count out of range");

  a_rx_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_bit_count <= TX_LAST_DATA)
    else $error("rx bit count out of range");

  a_send_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.operation == OP_SEND |=>
      sending_mode && tx_phase == TX_DATA && tx_bit_count == 4'd0 && rx_phase == RX_IDLE)
    else $error("send request did not restart transmit");
`endif

endmodule

// File: src/ps2_host_transceiver.sv
// PS/2 host transceiver.
// Input channel "items": one beat per falling device-clock edge (operation 0,
// data_bit = sampled data line) or per send request (operation 1, tx_byte).
// Output channel "results": exactly one beat per input beat, in order, giving
// the data-line drive (line_enable, line_low), a start_request pulse on send
// requests, a received frame (rx_valid, rx_byte, rx_error) and tx_status.
// Pipeline: an accepted beat is held in the input register, stepped through
// the core, and its result is held in the result register until it is taken.
// Throughput: one beat per cycle unless the output stalls; the protocol step
// is a single pass of logic between the input and result registers.
// Reset (rst, synchronous): receiver idle, transmitter off, both pipeline
// registers empty.
// Output stall: the result register holds; the input register fills and then
// items.ready drops until results.ready returns.
// Depends on ps2h_pkg, ps2h_if and ps2h_core.
`timescale 1ns / 1ps

module ps2_host_transceiver import ps2h_pkg::*; (
  input logic       clk,
  input logic       rst,
  ps2h_in_if.sink   items,
  ps2h_out_if.source results
);

  logic in_valid;
  in_t  in_item;
  logic out_valid;
  res_t out_res;
  res_t core_res;
  logic advance;

  assign advance     = in_valid && (!out_valid || results.ready);
  assign items.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_item.operation <= items.operation;
      in_item.data_bit  <= items.data_bit;
      in_item.tx_byte   <= items.tx_byte;
    end
  end

  ps2h_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign results.valid         = out_valid;
  assign results.line_enable   = out_res.line_enable;
  assign results.line_low      = out_res.line_low;
  assign results.start_request = out_res.start_request;
  assign results.rx_valid      = out_res.rx_valid;
  assign results.rx_byte       = out_res.rx_byte;
  assign results.rx_error      = out_res.rx_error;
  assign results.tx_status     = out_res.tx_status;

`ifndef SYNTHESIS
  a_low_needs_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_res.line_low || out_res.line_enable))
    else $error("line_low without line_enable");

  a_rx_fields_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.rx_valid |-> out_res.rx_byte == 8'd0 &&
      out_res.rx_error == RX_ERR_NONE)
    else $error("rx fields set without a frame");

  a_start_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.start_request |->
      out_res.line_enable && out_res.line_low && !out_res.rx_valid &&
      out_res.tx_status == TX_ST_NONE)
    else $error("start request mixed with other events");

  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("input register lost a stalled beat");

  a_result_pairing: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && out_res == $past(core_res))
    else $error("result register missed a step");
`endif

endmodule

// File: sim/ps2_host_transceiver_test.sv
// Self-checking testbench for ps2_host_transceiver: directed table, then random
// receive frames, transmit frames and broken sequences, scored against a local model.
// Depends on ps2h_pkg, ps2h_if and the ps2_host_transceiver RTL.
`timescale 1ns / 1ps

module ps2_host_transceiver_test;
  import ps2h_pkg::*;

  localparam int RAND_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    in_t  beat;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  ps2h_in_if  items_if ();
  ps2h_out_if results_if ();

  ps2_host_transceiver uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // line model state
  logic       tx_on = 1'b0;
  logic [1:0] tx_ph = TX_DATA;
  logic [7:0] tx_data = 8'h00;
  logic [3:0] tx_cnt = 4'd0;
  logic [1:0] rx_ph = RX_IDLE;
  logic [7:0] rx_sr = 8'h00;
  logic       rx_par = 1'b0;
  logic [3:0] rx_cnt = 4'd0;

  res_t        line_result_q[$];
  dir_row_t    dir_tab[$];
  int          err_cnt = 0;
  int          work_cnt = 0;
  int          burst_left = 0;
  int unsigned tick_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    tick_count <= tick_count + 1;
    if (tick_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic predict_line(input in_t b, output res_t r);
    r = '0;
    if (b.operation == OP_SEND) begin
      tx_on = 1'b1;
      tx_data = b.tx_byte;
      tx_cnt = 4'd0;
      tx_ph = TX_DATA;
      rx_ph = RX_IDLE;
      r.start_request = 1'b1;
      r.line_enable = 1'b1;
      r.line_low = 1'b1;
    end else if (tx_on) begin
      case (tx_ph)
        TX_DATA: begin
          r.line_enable = 1'b1;
          if (tx_cnt == 4'd0 || tx_cnt > TX_LAST_DATA) r.line_low = 1'b1;
          else r.line_low = ~tx_data[3'(tx_cnt - 4'd1)];
          tx_cnt = tx_cnt + 4'd1;
          if (tx_cnt >= TX_DATA_EDGES) tx_ph = TX_PARITY;
        end
        TX_PARITY: begin
          // odd parity: the driven bit is low when the byte already has odd ones
          r.line_enable = 1'b1;
          r.line_low = ^tx_data;
          tx_ph = TX_STOP;
        end
        TX_STOP: tx_ph = TX_ACK;
        default: begin
          r.tx_status = b.data_bit ? TX_ST_NO_ACK : TX_ST_ACKED;
          tx_ph = TX_DATA;
          tx_cnt = 4'd0;
          tx_on = 1'b0;
        end
      endcase
    end else begin
      case (rx_ph)
        RX_IDLE: begin
          if (!b.data_bit) begin
            rx_ph = RX_DATA;
            rx_sr = 8'h00;
            rx_par = 1'b0;
            rx_cnt = 4'd0;
          end
        end
        RX_DATA: begin
          rx_sr = {b.data_bit, rx_sr[7:1]};
          rx_par = rx_par ^ b.data_bit;
          rx_cnt = rx_cnt + 4'd1;
          if (rx_cnt > RX_LAST_INDEX) rx_ph = RX_PARITY;
        end
        RX_PARITY: begin
          if (rx_par == b.data_bit) begin
            r.rx_valid = 1'b1;
            r.rx_error = RX_ERR_PARITY;
            r.rx_byte = rx_sr;
            rx_ph = RX_IDLE;
          end else begin
            rx_ph = RX_STOP;
          end
        end
        default: begin
          r.rx_valid = 1'b1;
          r.rx_byte = rx_sr;
          r.rx_error = b.data_bit ? RX_ERR_NONE : RX_ERR_STOP;
          rx_ph = RX_IDLE;
        end
      endcase
    end
  endtask

  // Entered and left at a falling edge.
  task automatic send_beat(input in_t b, input bit typed, input res_t want);
    int   gap_len;
    res_t r;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        items_if.valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
    end
    burst_left--;
    items_if.valid <= 1'b1;
    items_if.operation <= b.operation;
    items_if.data_bit <= b.data_bit;
    items_if.tx_byte <= b.tx_byte;
    do @(posedge clk); while (!items_if.ready);
    // idle high edges only keep the receiver waiting
    if (!(b.operation == OP_EDGE && !tx_on && rx_ph == RX_IDLE && b.data_bit)) work_cnt++;
    predict_line(b, r);
    line_result_q.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic put_edge(input logic d);
    in_t b;
    b.operation = OP_EDGE;
    b.data_bit = d;
    b.tx_byte = 8'($urandom_range(255));
    send_beat(b, 1'b0, '0);
  endtask

  task automatic put_send(input logic [7:0] v);
    in_t b;
    b.operation = OP_SEND;
    b.data_bit = 1'($urandom_range(1));
    b.tx_byte = v;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic add_row(input logic op, input logic d, input logic [7:0] v,
                         input bit typed, input res_t want);
    dir_row_t row;
    row.beat.operation = op;
    row.beat.data_bit = d;
    row.beat.tx_byte = v;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic hold_until_empty;
    items_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (line_result_q.size() != 0);
  endtask

  task automatic rx_frame(input logic [7:0] v, input bit bad_par, input bit bad_stop);
    repeat ($urandom_range(2)) put_edge(1'b1);
    put_edge(1'b0);
    for (int i = 0; i < 8; i++) put_edge(v[i]);
    put_edge(bad_par ? ^v : ~^v);
    if (!bad_par) put_edge(!bad_stop);
  endtask

  task automatic tx_frame(input logic [7:0] v);
    put_send(v);
    repeat (11) put_edge(1'($urandom_range(1)));
    put_edge(1'($urandom_range(1)));  // device ack
  endtask

  initial begin
    int   pick;
    bit   held_mid;
    res_t want;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.operation = OP_EDGE;
    items_if.data_bit = 1'b1;
    items_if.tx_byte = 8'h00;
    held_mid = 1'b0;

    // idle line high: nothing happens
    add_row(OP_EDGE, 1'b1, 8'h00, 1'b1, '0);
    // 0xFF with a wrong parity bit ends at the parity edge
    add_row(OP_EDGE, 1'b0, 8'h00, 1'b0, '0);
    for (int i = 0; i < 8; i++) add_row(OP_EDGE, 1'b1, 8'h00, 1'b0, '0);
    want = {1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, RX_ERR_PARITY, TX_ST_NONE};
    add_row(OP_EDGE, 1'b0, 8'h00, 1'b1, want);
    // send cuts into a frame, a second send restarts the transfer
    add_row(OP_EDGE, 1'b0, 8'h00, 1'b0, '0);
    want = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, RX_ERR_NONE, TX_ST_NONE};
    add_row(OP_SEND, 1'b0, 8'hFF, 1'b1, want);
    add_row(OP_SEND, 1'b1, 8'h00, 1'b1, want);
    for (int i = 0; i < 11; i++) add_row(OP_EDGE, 1'b1, 8'h00, 1'b0, '0);
    want = {1'b0, 1'b0, 1'b0, 1'b0, 8'h00, RX_ERR_NONE, TX_ST_NO_ACK};
    add_row(OP_EDGE, 1'b1, 8'h00, 1'b1, want);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    hold_until_empty();
    work_cnt = 0;

    while (work_cnt < RAND_ITEMS) begin
      if (!held_mid && work_cnt > RAND_ITEMS / 2) begin
        held_mid = 1'b1;
        hold_until_empty();
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        rx_frame(8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (pick < 42) begin
        rx_frame(8'($urandom_range(255)), 1'b1, 1'b0);
      end else if (pick < 49) begin
        rx_frame(8'($urandom_range(255)), 1'b0, 1'b1);
      end else if (pick < 74) begin
        tx_frame(8'($urandom_range(255)));
      end else if (pick < 82) begin
        // transfer restarted part way through
        put_send(8'($urandom_range(255)));
        repeat ($urandom_range(11)) put_edge(1'($urandom_range(1)));
        tx_frame(8'($urandom_range(255)));
      end else if (pick < 90) begin
        // receive frame dropped by a send request
        put_edge(1'b0);
        repeat ($urandom_range(9)) put_edge(1'($urandom_range(1)));
        tx_frame(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(7) == 0) put_send(8'($urandom_range(255)));
          else put_edge(1'($urandom_range(1)));
        end
      end
    end

    hold_until_empty();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver stall patterns: free-running, light, heavy and a square wave.
  initial begin
    int mode;
    int span;
    int phase_cnt;
    results_if.ready = 1'b0;
    phase_cnt = 0;
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        phase_cnt++;
        case (mode)
          0: results_if.ready <= 1'b1;
          1: results_if.ready <= ($urandom_range(3) != 0);
          2: results_if.ready <= ($urandom_range(3) == 0);
          default: results_if.ready <= ((phase_cnt % 12) < 4);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && results_if.valid && results_if.ready) begin
      if (line_result_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        exp_res = line_result_q.pop_front();
        if (results_if.line_enable !== exp_res.line_enable) begin
          $error("line_enable: expected %0d, got %0d", exp_res.line_enable,
                 results_if.line_enable);
          err_cnt++;
        end
        if (results_if.line_low !== exp_res.line_low) begin
          $error("line_low: expected %0d, got %0d", exp_res.line_low, results_if.line_low);
          err_cnt++;
        end
        if (results_if.start_request !== exp_res.start_request) begin
          $error("start_request: expected %0d, got %0d", exp_res.start_request,
                 results_if.start_request);
          err_cnt++;
        end
        if (results_if.rx_valid !== exp_res.rx_valid) begin
          $error("rx_valid: expected %0d, got %0d", exp_res.rx_valid, results_if.rx_valid);
          err_cnt++;
        end
        if (results_if.rx_byte !== exp_res.rx_byte) begin
          $error("rx_byte: expected %02h, got %02h", exp_res.rx_byte, results_if.rx_byte);
          err_cnt++;
        end
        if (results_if.rx_error !== exp_res.rx_error) begin
          $error("rx_error: expected %0d, got %0d", exp_res.rx_error, results_if.rx_error);
          err_cnt++;
        end
        if (results_if.tx_status !== exp_res.tx_status) begin
          $error("tx_status: expected %0d, got %0d", exp_res.tx_status,
                 results_if.tx_status);
          err_cnt++;
        end
      end
    end
  end

endmodule
